@@ rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int          MAX_BOXES_DEF = 64;
    localparam logic [15:0] IOU_THR_RESET = 16'd13107;

    typedef struct packed {
        logic [15:0]        score;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [12:0]        tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        RD_LOW,
        RD_HOLE,
        RD_SEL,
        RD_IDX
    } t_rd_src;

    typedef struct packed {
        logic    load;
        t_rd_src rd_src;
        logic    hole_from_count;
        logic    hole_from_max;
        logic    set_ovf;
        logic    wr_shift;
        logic    wr_new;
        logic    sel_inc;
        logic    cap_a;
        logic    idx_inc;
        logic    iou_start;
        logic    iou_retire;
        logic    clear_set;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic full;
        logic rd_ge;
        logic hole_zero;
        logic sel_end;
        logic sel_masked;
        logic idx_end;
        logic idx_masked;
        logic iou_done;
    } t_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_LOWCMP,
        ST_SH_RD,
        ST_SH_CMP,
        ST_SEL,
        ST_SEL_RD,
        ST_CMP_RD,
        ST_CMP_GO,
        ST_CMP_WAIT,
        ST_EMIT,
        ST_END
    } t_state;

endpackage

`default_nettype wire

@@ rtl/gbs_ram.sv @@
// ----------------------------------------------------------------------------
// gbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/gbs_iou.sv @@
// ----------------------------------------------------------------------------
// gbs_iou
// Five-stage overlap test: intersection over union against the threshold,
// cross-multiplied so that no division is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_iou
    import gbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_entry      i_a,
    input  wire t_entry      i_b,
    input  wire logic [15:0] i_thr,
    output logic             o_done,
    output logic             o_hit
);

    logic signed [15:0] min_x2, max_x1, min_y2, max_y1;
    logic signed [17:0] r_iw, r_ih, r_wa, r_ha, r_wb, r_hb;
    logic signed [35:0] r_inter, r_a1, r_a2, r_inter3;
    logic               r_pos2, r_pos3, r_pos4;
    logic signed [37:0] r_uni, r_uni4;
    logic signed [35:0] r_inter4;
    logic        [34:0] r_plo;
    logic signed [35:0] r_phi;
    logic signed [18:0] uni_hi;
    logic signed [55:0] prod, inter_sh;
    logic               r_v1, r_v2, r_v3, r_v4;

    assign min_x2 = (i_a.right  < i_b.right)  ? i_a.right  : i_b.right;
    assign max_x1 = (i_a.left   > i_b.left)   ? i_a.left   : i_b.left;
    assign min_y2 = (i_a.bottom < i_b.bottom) ? i_a.bottom : i_b.bottom;
    assign max_y1 = (i_a.top    > i_b.top)    ? i_a.top    : i_b.top;

    assign uni_hi   = r_uni[37:19];
    assign prod     = (56'(r_phi) <<< 19) + 56'(r_plo);
    assign inter_sh = 56'(r_inter4) <<< 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            o_done <= r_v4;
        end
        // Stage 1: edges of the intersection and both boxes, +1 pixel included.
        r_iw <= 18'(min_x2) - 18'(max_x1) + 18'sd16;
        r_ih <= 18'(min_y2) - 18'(max_y1) + 18'sd16;
        r_wa <= 18'(i_a.right)  - 18'(i_a.left) + 18'sd16;
        r_ha <= 18'(i_a.bottom) - 18'(i_a.top)  + 18'sd16;
        r_wb <= 18'(i_b.right)  - 18'(i_b.left) + 18'sd16;
        r_hb <= 18'(i_b.bottom) - 18'(i_b.top)  + 18'sd16;
        // Stage 2: areas.
        r_inter <= r_iw * r_ih;
        r_a1    <= r_wa * r_ha;
        r_a2    <= r_wb * r_hb;
        r_pos2  <= (r_iw > 18'sd0) && (r_ih > 18'sd0);
        // Stage 3: union.
        r_uni    <= 38'(r_a1) + 38'(r_a2) - 38'(r_inter);
        r_inter3 <= r_inter;
        r_pos3   <= r_pos2;
        // Stage 4: threshold times union, split into two narrow products.
        r_plo    <= 35'(i_thr) * 35'(r_uni[18:0]);
        r_phi    <= 36'($signed({1'b0, i_thr})) * 36'(uni_hi);
        r_uni4   <= r_uni;
        r_inter4 <= r_inter3;
        r_pos4   <= r_pos3;
        // Stage 5: decision. A zero union counts as an infinite ratio.
        o_hit <= r_pos4 && ((r_uni4 == 38'sd0)
                 || ((r_uni4 > 38'sd0) && (inter_sh > prod)));
    end

    a_done_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 5))
        else $error("overlap result without a matching start");

endmodule

`default_nettype wire

@@ rtl/gbs_dp.sv @@
// ----------------------------------------------------------------------------
// gbs_dp
// Datapath: box store, insertion pointers, suppression mask, overlap unit
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_dp
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire t_entry      i_entry,
    input  wire logic        i_last,
    output t_entry           o_kept,
    output logic             o_ovf,
    output logic             o_last
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    t_entry                r_in;
    logic                  r_last;
    logic [CW-1:0]         r_count;
    logic                  r_ovf;
    logic [IW-1:0]         r_hole;
    logic [CW-1:0]         r_sel, r_idx;
    logic [MAX_BOXES-1:0]  r_mask;
    t_entry                r_a;
    logic [15:0]           r_thr;
    logic [IW-1:0]         raddr;
    logic [ENTRY_W-1:0]    rdata_raw;
    t_entry                rdata;
    t_entry                wdata;
    logic                  we;
    logic                  full;
    logic                  iou_done, iou_hit;
    logic                  more;

    assign rdata = t_entry'(rdata_raw);
    assign full  = (r_count == CW'(MAX_BOXES));
    assign we    = i_cmd.wr_shift | i_cmd.wr_new;
    assign wdata = i_cmd.wr_shift ? rdata : r_in;

    always_comb begin
        case (i_cmd.rd_src)
            RD_LOW:  raddr = IW'(MAX_BOXES - 1);
            RD_HOLE: raddr = r_hole - 1'b1;
            RD_SEL:  raddr = r_sel[IW-1:0];
            RD_IDX:  raddr = r_idx[IW-1:0];
            default: raddr = r_hole;
        endcase
    end

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_hole),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    gbs_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.iou_start),
        .i_a     (r_a),
        .i_b     (rdata),
        .i_thr   (r_thr),
        .o_done  (iou_done),
        .o_hit   (iou_hit)
    );

    // The kept box is the final one when no live box follows it in the store.
    always_comb begin
        more = 1'b0;
        for (int j = 0; j < MAX_BOXES; j++) begin
            if ((CW'(j) > r_sel) && (CW'(j) < r_count) && !r_mask[j]) begin
                more = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.in_last    = r_last;
        o_stat.full       = full;
        o_stat.rd_ge      = (rdata.score >= r_in.score);
        o_stat.hole_zero  = (r_hole == '0);
        o_stat.sel_end    = (r_sel >= r_count);
        o_stat.sel_masked = r_mask[r_sel[IW-1:0]];
        o_stat.idx_end    = (r_idx >= r_count);
        o_stat.idx_masked = r_mask[r_idx[IW-1:0]];
        o_stat.iou_done   = iou_done;
    end

    assign o_kept = r_a;
    assign o_ovf  = r_ovf;
    assign o_last = !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_mask  <= '0;
            r_thr   <= IOU_THR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.wr_new && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.iou_retire && iou_hit) begin
                r_mask[r_idx[IW-1:0]] <= 1'b1;
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_mask  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in   <= i_entry;
            r_last <= i_last;
            r_sel  <= '0;
        end
        if (i_cmd.hole_from_count) begin
            r_hole <= r_count[IW-1:0];
        end
        if (i_cmd.hole_from_max) begin
            r_hole <= IW'(MAX_BOXES - 1);
        end
        if (i_cmd.wr_shift) begin
            r_hole <= r_hole - 1'b1;
        end
        if (i_cmd.sel_inc) begin
            r_sel <= r_sel + 1'b1;
        end
        if (i_cmd.cap_a) begin
            r_a   <= rdata;
            r_idx <= r_sel + 1'b1;
        end
        if (i_cmd.idx_inc || i_cmd.iou_retire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES))
        else $error("box count beyond store depth");

    a_shift_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_shift |-> (r_hole != '0))
        else $error("shift below the first entry");

endmodule

`default_nettype wire

@@ rtl/gbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbs_ctrl
// Controller: sorted insertion sequence, then the greedy suppression scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ctrl
    import gbs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.rd_src = RD_HOLE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.full) begin
                    o_cmd.rd_src = RD_LOW;
                    n_state      = ST_LOWCMP;
                end else begin
                    o_cmd.hole_from_count = 1'b1;
                    n_state               = ST_SH_RD;
                end
            end
            ST_LOWCMP: begin
                o_cmd.set_ovf = 1'b1;
                if (i_stat.rd_ge) begin
                    // The new box does not beat the lowest one: it is dropped.
                    n_state = i_stat.in_last ? ST_SEL : ST_IDLE;
                end else begin
                    o_cmd.hole_from_max = 1'b1;
                    n_state             = ST_SH_RD;
                end
            end
            ST_SH_RD: begin
                if (i_stat.hole_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = i_stat.in_last ? ST_SEL : ST_IDLE;
                end else begin
                    o_cmd.rd_src = RD_HOLE;
                    n_state      = ST_SH_CMP;
                end
            end
            ST_SH_CMP: begin
                if (i_stat.rd_ge) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = i_stat.in_last ? ST_SEL : ST_IDLE;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = ST_SH_RD;
                end
            end
            ST_SEL: begin
                if (i_stat.sel_end) begin
                    n_state = ST_END;
                end else if (i_stat.sel_masked) begin
                    o_cmd.sel_inc = 1'b1;
                end else begin
                    o_cmd.rd_src = RD_SEL;
                    n_state      = ST_SEL_RD;
                end
            end
            ST_SEL_RD: begin
                o_cmd.cap_a = 1'b1;
                n_state     = ST_CMP_RD;
            end
            ST_CMP_RD: begin
                if (i_stat.idx_end) begin
                    n_state = ST_EMIT;
                end else if (i_stat.idx_masked) begin
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.rd_src = RD_IDX;
                    n_state      = ST_CMP_GO;
                end
            end
            ST_CMP_GO: begin
                o_cmd.iou_start = 1'b1;
                n_state         = ST_CMP_WAIT;
            end
            ST_CMP_WAIT: begin
                if (i_stat.iou_done) begin
                    o_cmd.iou_retire = 1'b1;
                    n_state          = ST_CMP_RD;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.sel_inc = 1'b1;
                    n_state       = ST_SEL;
                end
            end
            ST_END: begin
                o_cmd.clear_set = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_state)))
        else $error("result withdrawn before it was taken");

endmodule

`default_nettype wire

@@ rtl/greedy_box_suppression.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Sorted box store with greedy non-maximum suppression by overlap ratio.
//
//   channel  direction  handshake                     beat
//   in       input      i_in_valid / o_in_ready       one scored box
//   out      output     o_out_valid / i_out_ready     one kept box
//   cfg      input      i_cfg_we                      overlap threshold
//
// Loading a box walks it down from the end of the store, one read and one write of
// the single store RAM per entry it moves past, until it meets an entry that scores
// at least as high or reaches the front. A full store first reads its lowest entry;
// a box that does not beat that entry is dropped.
// After the last box, each live box is selected and compared in turn to every later
// live box by the five-stage overlap unit, waiting for each result; boxes already
// suppressed are skipped, then the kept box is sent out. A final state closes the set.
// A stalled output beat holds the block; no box is taken while a set is drained.
// Reset is synchronous, active low, and leaves the block idle and empty.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [15:0] i_score,
    input  wire logic signed [15:0] i_left_x,
    input  wire logic signed [15:0] i_top_y,
    input  wire logic signed [15:0] i_right_x,
    input  wire logic signed [15:0] i_bottom_y,
    input  wire logic        [12:0] i_tag,
    input  wire logic               i_last_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [15:0] o_kept_score,
    output logic signed      [15:0] o_kept_left,
    output logic signed      [15:0] o_kept_top,
    output logic signed      [15:0] o_kept_right,
    output logic signed      [15:0] o_kept_bottom,
    output logic             [12:0] o_kept_tag,
    output logic                    o_overflowed,
    output logic                    o_last_out,
    input  wire logic               i_cfg_we,
    input  wire logic        [15:0] i_cfg_wdata
);

    t_cmd   cmd;
    t_stat  stat;
    t_entry in_entry;
    t_entry kept;

    always_comb begin
        in_entry.score  = i_score;
        in_entry.left   = i_left_x;
        in_entry.top    = i_top_y;
        in_entry.right  = i_right_x;
        in_entry.bottom = i_bottom_y;
        in_entry.tag    = i_tag;
    end

    gbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gbs_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_entry     (in_entry),
        .i_last      (i_last_in),
        .o_kept      (kept),
        .o_ovf       (o_overflowed),
        .o_last      (o_last_out)
    );

    assign o_kept_score  = kept.score;
    assign o_kept_left   = kept.left;
    assign o_kept_top    = kept.top;
    assign o_kept_right  = kept.right;
    assign o_kept_bottom = kept.bottom;
    assign o_kept_tag    = kept.tag;

endmodule

`default_nettype wire
